// File: sv/qeb_pkg.sv
// Shared types and constants for the quadrature encoder bank.
package qeb_pkg;

   // Item command codes
   typedef enum logic {
      CMD_POLL    = 1'b0,
      CMD_CONSUME = 1'b1
   } cmd_type;

   // Decoded quadrature step
   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_UP   = 2'd1,
      STEP_DOWN = 2'd2
   } step_type;

   // Per-lane control from the update stage
   typedef struct packed {
      logic poll;      // apply this item's phase pair
      logic counting;  // phases were captured before, so count steps
      logic clear;     // consume item reads and clears this lane
   } lane_ctl_type;

   localparam int PIN_LANES = 4;
   localparam int PHASE_WIDTH = 2;
   localparam int DELTA_WIDTH = 32;
   localparam int MILLI_WIDTH = 32;
   localparam int MICRO_WIDTH = 64;
   localparam int ELAPSED_WIDTH = 32;
   localparam int RES_WIDTH = 10;
   localparam int QUOT_WIDTH = 23;

   localparam logic [RES_WIDTH-1:0] US_PER_MS = 10'd1000;
   // ceil(2^36 / 125): exact quotient for any 29-bit dividend
   localparam logic [29:0] RECIP_125 = 30'd549755814;
   localparam int RECIP_SHIFT = 36;

   // Transition table: last phase pair to new phase pair
   function automatic step_type phase_step(input logic [1:0] last_ph,
                                           input logic [1:0] now_ph);
      step_type s;
      s = STEP_NONE;
      case ({last_ph, now_ph})
         4'b00_01: s = STEP_DOWN;
         4'b00_10: s = STEP_UP;
         4'b01_00: s = STEP_UP;
         4'b01_11: s = STEP_DOWN;
         4'b10_00: s = STEP_DOWN;
         4'b10_11: s = STEP_UP;
         4'b11_01: s = STEP_UP;
         4'b11_10: s = STEP_DOWN;
         default:  s = STEP_NONE;
      endcase
      return s;
   endfunction

endpackage

// File: sv/qeb_if.sv
// Valid/ready channel interfaces for poll/consume items and result items.
interface qeb_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  encoder_pins;
   logic [31:0] elapsed_us;
   logic [1:0]  encoder_index;

   modport source (output valid, output command, output encoder_pins,
                   output elapsed_us, output encoder_index, input ready);
   modport sink   (input valid, input command, input encoder_pins,
                   input elapsed_us, input encoder_index, output ready);
endinterface

interface qeb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] delta_value;
   logic [31:0]        millis_now;
   logic [63:0]        micros_now;

   modport source (output valid, output delta_value, output millis_now,
                   output micros_now, input ready);
   modport sink   (input valid, input delta_value, input millis_now,
                   input micros_now, output ready);
endinterface

// File: sv/qeb_lane.sv
// One encoder lane: last phase pair and wrapping signed step total.
module qeb_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [qeb_pkg::PHASE_WIDTH-1:0]     phase,
   input  qeb_pkg::lane_ctl_type               ctl,
   output logic [qeb_pkg::DELTA_WIDTH-1:0]     total
);

   logic [qeb_pkg::PHASE_WIDTH-1:0] last_phase_ff, last_phase_in;
   logic [qeb_pkg::DELTA_WIDTH-1:0] total_ff, total_in;
   qeb_pkg::step_type               step;

   // Decode the transition from the stored phase pair
   assign step = qeb_pkg::phase_step(last_phase_ff, phase);

   // Hold, advance or clear the lane state
   always_comb begin
      last_phase_in = last_phase_ff;
      total_in      = total_ff;
      if (ctl.poll) begin
         last_phase_in = phase;
         if (ctl.counting) begin
            case (step)
               qeb_pkg::STEP_UP:   total_in = total_ff + 32'd1;
               qeb_pkg::STEP_DOWN: total_in = total_ff - 32'd1;
               default:            total_in = total_ff;
            endcase
         end
      end else if (ctl.clear) begin
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_phase_ff <= '0;
         total_ff      <= '0;
      end else begin
         last_phase_ff <= last_phase_in;
         total_ff      <= total_in;
      end
   end

   assign total = total_ff;

endmodule

// File: sv/quadrature_encoder_bank_with_clock.sv
// Quadrature encoder bank with microsecond and millisecond time base.
//
// Usage:
//   req_chan carries one item per valid/ready handshake. A poll item
//   (command = poll) brings the A/B phase pairs of all encoders and the
//   microseconds elapsed since the previous poll; a consume item
//   (command = consume) names one encoder whose step delta is returned
//   and cleared. The first poll after reset only captures the phases.
//   rsp_chan returns exactly one item per request, in order, carrying the
//   consumed delta (zero for polls), the millisecond count and the
//   microsecond total after that item.
// Timing:
//   Four register stages: input, quotient by 1000, remainder, result.
//   One item is accepted every cycle unless every stage is full and
//   rsp_chan stalls. The 29x30 reciprocal multiply that splits elapsed
//   time into milliseconds sets the pipeline depth.
// Reset and stall:
//   Synchronous reset clears all deltas, phases and both clocks and
//   empties the pipeline. When rsp_chan stalls, the result is held and
//   the stages behind it keep filling; req_chan.ready drops only when
//   every stage holds an item.
module quadrature_encoder_bank_with_clock #(
   parameter int ENCODER_COUNT = 4
) (
   input  logic            clock,
   input  logic            reset,
   qeb_req_if.sink         req_chan,
   qeb_rsp_if.source       rsp_chan
);

   localparam int DW = qeb_pkg::DELTA_WIDTH;
   localparam int EW = qeb_pkg::ELAPSED_WIDTH;
   localparam int RW = qeb_pkg::RES_WIDTH;
   localparam int QW = qeb_pkg::QUOT_WIDTH;
   localparam int PW = EW - 3 + 30;

   // Stage valids and per-stage ready
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s4_ready, s3_ready, s2_ready, s1_ready;
   logic s1_load, s2_load, s3_load, s4_load;

   // Pipeline payload
   logic          s1_cmd_ff, s2_cmd_ff, s3_cmd_ff;
   logic [7:0]    s1_pins_ff, s2_pins_ff, s3_pins_ff;
   logic [EW-1:0] s1_elapsed_ff, s2_elapsed_ff, s3_elapsed_ff;
   logic [1:0]    s1_index_ff, s2_index_ff, s3_index_ff;
   logic [QW-1:0] s2_quot_ff, s3_quot_ff;
   logic [RW-1:0] s3_rem_ff;

   // Block state
   logic                          phase_captured_ff, phase_captured_in;
   logic [qeb_pkg::MICRO_WIDTH-1:0] micro_total_ff, micro_total_in;
   logic [qeb_pkg::MILLI_WIDTH-1:0] milli_total_ff, milli_total_in;
   logic [RW-1:0]                 micro_res_ff, micro_res_in;

   // Result register
   logic [DW-1:0] rsp_delta_ff;

   logic [PW-1:0] recip_prod;
   logic [RW-1:0] quot_low_x1000;
   logic [RW:0]   res_sum;
   logic          res_carry;
   logic          s3_poll, s3_consume;
   logic [DW-1:0] delta_sel;

   qeb_pkg::lane_ctl_type           lane_ctl   [ENCODER_COUNT];
   logic [qeb_pkg::PHASE_WIDTH-1:0] lane_phase [ENCODER_COUNT];
   logic [DW-1:0]                   lane_total [ENCODER_COUNT];

   // Ready chain: a stage takes an item when it is empty or moves on
   assign s4_ready = !s4_valid_ff || rsp_chan.ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_chan.ready = s1_ready;

   assign s1_load = req_chan.valid && s1_ready;
   assign s2_load = s1_valid_ff && s2_ready;
   assign s3_load = s2_valid_ff && s3_ready;
   assign s4_load = s3_valid_ff && s4_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_chan.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_cmd_ff     <= req_chan.command;
         s1_pins_ff    <= req_chan.encoder_pins;
         s1_elapsed_ff <= req_chan.elapsed_us;
         s1_index_ff   <= req_chan.encoder_index;
      end
   end

   // Quotient by 1000: (elapsed >> 3) / 125 through the reciprocal
   assign recip_prod = PW'(s1_elapsed_ff[EW-1:3]) * PW'(qeb_pkg::RECIP_125);

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_cmd_ff     <= s1_cmd_ff;
         s2_pins_ff    <= s1_pins_ff;
         s2_elapsed_ff <= s1_elapsed_ff;
         s2_index_ff   <= s1_index_ff;
         s2_quot_ff    <= recip_prod[qeb_pkg::RECIP_SHIFT +: QW];
      end
   end

   // Remainder below 1000 fits in 10 bits, so work modulo 1024
   assign quot_low_x1000 = RW'(s2_quot_ff[RW-1:0] * qeb_pkg::US_PER_MS);

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_cmd_ff     <= s2_cmd_ff;
         s3_pins_ff    <= s2_pins_ff;
         s3_elapsed_ff <= s2_elapsed_ff;
         s3_index_ff   <= s2_index_ff;
         s3_quot_ff    <= s2_quot_ff;
         s3_rem_ff     <= s2_elapsed_ff[RW-1:0] - quot_low_x1000;
      end
   end

   assign s3_poll    = s4_load && (s3_cmd_ff == qeb_pkg::CMD_POLL);
   assign s3_consume = s4_load && (s3_cmd_ff == qeb_pkg::CMD_CONSUME);

   // Encoder lanes
   genvar k;
   generate
      for (k = 0; k < ENCODER_COUNT; k++) begin : g_lane
         if (k < qeb_pkg::PIN_LANES) begin : g_pin
            assign lane_phase[k] = s3_pins_ff[2*k +: 2];
         end else begin : g_nopin
            assign lane_phase[k] = '0;
         end

         assign lane_ctl[k].poll     = s3_poll;
         assign lane_ctl[k].counting = phase_captured_ff;
         assign lane_ctl[k].clear    = s3_consume && (k == int'(s3_index_ff));

         qeb_lane u_lane (
            .clock (clock),
            .reset (reset),
            .phase (lane_phase[k]),
            .ctl   (lane_ctl[k]),
            .total (lane_total[k])
         );
      end
   endgenerate

   // Select the consumed delta; an index past the bank reads zero
   always_comb begin
      delta_sel = '0;
      for (int i = 0; i < ENCODER_COUNT; i++) begin
         if (i == int'(s3_index_ff)) delta_sel = lane_total[i];
      end
   end

   // Advance both clocks on a poll
   assign res_sum   = {1'b0, micro_res_ff} + {1'b0, s3_rem_ff};
   assign res_carry = (res_sum >= {1'b0, qeb_pkg::US_PER_MS});

   always_comb begin
      phase_captured_in = phase_captured_ff;
      micro_total_in    = micro_total_ff;
      milli_total_in    = milli_total_ff;
      micro_res_in      = micro_res_ff;
      if (s3_poll) begin
         phase_captured_in = 1'b1;
         micro_total_in    = micro_total_ff
                           + qeb_pkg::MICRO_WIDTH'(s3_elapsed_ff);
         milli_total_in    = milli_total_ff
                           + qeb_pkg::MILLI_WIDTH'(s3_quot_ff)
                           + qeb_pkg::MILLI_WIDTH'(res_carry);
         micro_res_in      = res_carry ? RW'(res_sum - {1'b0, qeb_pkg::US_PER_MS})
                                       : RW'(res_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_captured_ff <= 1'b0;
         micro_total_ff    <= '0;
         milli_total_ff    <= '0;
         micro_res_ff      <= '0;
      end else begin
         phase_captured_ff <= phase_captured_in;
         micro_total_ff    <= micro_total_in;
         milli_total_ff    <= milli_total_in;
         micro_res_ff      <= micro_res_in;
      end
   end

   // Result register; the clocks are read from the state just written
   always_ff @(posedge clock) begin
      if (s4_load) begin
         rsp_delta_ff <= s3_consume ? delta_sel : '0;
      end
   end

   assign rsp_chan.valid       = s4_valid_ff;
   assign rsp_chan.delta_value = rsp_delta_ff;
   assign rsp_chan.millis_now  = milli_total_ff;
   assign rsp_chan.micros_now  = micro_total_ff;

   // Residual stays below one millisecond
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      micro_res_ff < qeb_pkg::US_PER_MS)
      else $error("millisecond residual out of range");

   // A consume item leaves the clocks alone
   a_consume_clock: assert property (@(posedge clock) disable iff (reset)
      (s4_load && s3_cmd_ff == qeb_pkg::CMD_CONSUME) |=>
         $stable(micro_total_ff) && $stable(milli_total_ff))
      else $error("clock advanced on consume item");

   // Clocks only move when an item enters the result register
   a_clock_hold: assert property (@(posedge clock) disable iff (reset)
      !s4_load |=> $stable(micro_total_ff) && $stable(micro_res_ff))
      else $error("clock changed without a result");

   // Once captured, phases stay captured until reset
   a_captured: assert property (@(posedge clock) disable iff (reset)
      phase_captured_ff |=> phase_captured_ff)
      else $error("phase capture flag dropped");

   // A full pipeline facing a stalled receiver refuses new items
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && !rsp_chan.ready)
         |-> !req_chan.ready)
      else $error("item accepted into a full pipeline");

endmodule

// File: test/quadrature_encoder_bank_with_clock_test.sv
// Self-checking testbench for the quadrature encoder bank with its time base.
`timescale 1ns / 1ps

module quadrature_encoder_bank_with_clock_test;

   localparam int LANES = 4;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_ITEMS = 282;

   typedef struct {
      logic signed [31:0] delta;
      logic [31:0]        millis;
      logic [63:0]        micros;
   } encoder_result_type;

   logic clock;
   logic reset;

   qeb_req_if req_chan ();
   qeb_rsp_if rsp_chan ();

   quadrature_encoder_bank_with_clock dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predicted block state
   logic [1:0]  phase_seen [LANES];
   logic        phases_captured;
   logic [31:0] step_sum [LANES];
   logic [63:0] micros_total;
   logic [31:0] millis_total;
   logic [9:0]  micros_left;

   encoder_result_type pending_results[$];
   int error_count;
   int sender_idle_pct;
   int receiver_stall_pct;
   int idle_cycles;

   // Position of a phase pair along the forward rotation 00, 10, 11, 01
   function automatic int rotation_pos(input logic [1:0] ph);
      case (ph)
         2'b00:   return 0;
         2'b10:   return 1;
         2'b11:   return 2;
         default: return 3;
      endcase
   endfunction

   function automatic logic [1:0] rotation_phase(input int pos);
      case (pos % 4)
         0:       return 2'b00;
         1:       return 2'b10;
         2:       return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   // Advance the predicted state by one accepted item and return its result
   function automatic encoder_result_type predict_encoder_item(
         input qeb_pkg::cmd_type cmd,
         input logic [7:0] pins,
         input logic [31:0] elapsed,
         input logic [1:0] idx);
      encoder_result_type res;
      logic [63:0] acc;
      logic [1:0] now_ph;
      int quarter_steps;
      res.delta = '0;
      if (cmd == qeb_pkg::CMD_POLL) begin
         if (elapsed != 0) begin
            micros_total = micros_total + 64'(elapsed);
            acc = 64'(micros_left) + 64'(elapsed);
            millis_total = millis_total + 32'(acc / 1000);
            micros_left = 10'(acc % 1000);
         end
         for (int k = 0; k < LANES; k++) begin
            now_ph = pins[2*k +: 2];
            if (phases_captured && now_ph != phase_seen[k]) begin
               quarter_steps = (rotation_pos(now_ph) - rotation_pos(phase_seen[k]) + 4) % 4;
               // one quarter forward counts up, one back counts down, a jump is dropped
               if (quarter_steps == 1)
                  step_sum[k] = step_sum[k] + 32'd1;
               else if (quarter_steps == 3)
                  step_sum[k] = step_sum[k] - 32'd1;
            end
            phase_seen[k] = now_ph;
         end
         phases_captured = 1'b1;
      end else begin
         res.delta = step_sum[idx];
         step_sum[idx] = '0;
      end
      res.millis = millis_total;
      res.micros = micros_total;
      return res;
   endfunction

   // Clock generation
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Send one item, idling at random before it, and record its prediction
   task automatic send_encoder_item(input qeb_pkg::cmd_type cmd, input logic [7:0] pins,
                                    input logic [31:0] elapsed, input logic [1:0] idx);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= cmd;
      req_chan.encoder_pins <= pins;
      req_chan.elapsed_us <= elapsed;
      req_chan.encoder_index <= idx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_results.push_back(predict_encoder_item(cmd, pins, elapsed, idx));
   endtask

   // Hold the sender idle until every outstanding result has come back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Consume before any poll, a first poll that only captures phases, then a second poll
   task automatic test_startup();
      send_encoder_item(qeb_pkg::CMD_CONSUME, 8'h00, 32'h0000_0000, 2'd3);
      send_encoder_item(qeb_pkg::CMD_POLL, 8'hFF, 32'hFFFF_FFFF, 2'd0);
      send_encoder_item(qeb_pkg::CMD_POLL, 8'hFF, 32'h0000_0000, 2'd2);
   endtask

   // Walk every lane through all sixteen phase transitions, then read back
   task automatic test_phase_transitions();
      int walk [17];
      logic [7:0] pins;
      walk = '{0, 0, 1, 1, 2, 2, 3, 3, 0, 2, 0, 3, 1, 3, 2, 1, 0};
      for (int i = 0; i < 17; i++) begin
         for (int k = 0; k < LANES; k++)
            pins[2*k +: 2] = 2'(walk[i]) ^ 2'(k);
         send_encoder_item(qeb_pkg::CMD_POLL, pins, 32'(i * 251), 2'(i));
      end
      // ignored fields at their maximum must not move the clocks
      for (int k = 0; k < LANES; k++)
         send_encoder_item(qeb_pkg::CMD_CONSUME, 8'hFF, 32'hFFFF_FFFF, 2'(k));
   endtask

   // Mostly legal motion with random timing, plus jumps, noise and consumes
   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      logic [7:0] pins;
      logic [31:0] elapsed;
      int pick;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2)
            wait_for_results();
         for (int k = 0; k < LANES; k++) begin
            pick = $urandom_range(99);
            if (pick < 50)
               pins[2*k +: 2] = rotation_phase(rotation_pos(phase_seen[k]) +
                                               ($urandom_range(1) ? 1 : 3));
            else if (pick < 75)
               pins[2*k +: 2] = phase_seen[k];
            else if (pick < 90)
               pins[2*k +: 2] = phase_seen[k] ^ 2'b11;
            else
               pins[2*k +: 2] = 2'($urandom_range(3));
         end
         pick = $urandom_range(99);
         if (pick < 20)
            elapsed = '0;
         else if (pick < 50)
            elapsed = $urandom_range(2500);
         else if (pick < 75)
            elapsed = $urandom;
         else
            elapsed = 32'hFFFF_FFFF - $urandom_range(1000);
         if ($urandom_range(99) < 22)
            send_encoder_item(qeb_pkg::CMD_CONSUME, pins, elapsed, 2'($urandom_range(3)));
         else
            send_encoder_item(qeb_pkg::CMD_POLL, pins, elapsed, 2'($urandom_range(3)));
      end
      wait_for_results();
   endtask

   // Check each accepted result against the oldest prediction
   always @(posedge clock) begin
      encoder_result_type exp_res;
      if (rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: delta_value %0d", rsp_chan.delta_value);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_chan.delta_value !== exp_res.delta) begin
               $error("delta_value: expected %0d, got %0d", exp_res.delta,
                      rsp_chan.delta_value);
               error_count++;
            end
            if (rsp_chan.millis_now !== exp_res.millis) begin
               $error("millis_now: expected %0d, got %0d", exp_res.millis,
                      rsp_chan.millis_now);
               error_count++;
            end
            if (rsp_chan.micros_now !== exp_res.micros) begin
               $error("micros_now: expected %0d, got %0d", exp_res.micros,
                      rsp_chan.micros_now);
               error_count++;
            end
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog: stop when no item moves on either channel for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("** quadrature_encoder_bank_with_clock: FAILED **");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.command = qeb_pkg::CMD_POLL;
      req_chan.encoder_pins = '0;
      req_chan.elapsed_us = '0;
      req_chan.encoder_index = '0;
      rsp_chan.ready = 1'b0;
      error_count = 0;
      idle_cycles = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      phases_captured = 1'b0;
      micros_total = '0;
      millis_total = '0;
      micros_left = '0;
      for (int k = 0; k < LANES; k++) begin
         phase_seen[k] = '0;
         step_sum[k] = '0;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_startup();
      test_phase_transitions();
      wait_for_results();
      test_random_traffic(RANDOM_ITEMS, 0, 0);
      test_random_traffic(RANDOM_ITEMS, 62, 0);
      test_random_traffic(RANDOM_ITEMS, 0, 62);
      test_random_traffic(RANDOM_ITEMS, 14, 14);

      // drain, then watch for stray results
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("** quadrature_encoder_bank_with_clock: PASSED **");
      else
         $display("** quadrature_encoder_bank_with_clock: FAILED **");
      $finish;
   end

endmodule
